>>> src/bdy_pkg.sv
// ----------------------------------------------------------------------------
// bdy_pkg
// Shared types and codes for the buddy allocator: request and result
// payloads, status and mode codes, sequencer states.
// ----------------------------------------------------------------------------
package bdy_pkg;

  // default heap depth in levels (heap of 2^levels units)
  localparam int HEAP_LEVELS_DEF = 10;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NOSPACE = 2'd1;
  localparam logic [1:0] STATUS_TOOBIG  = 2'd2;

  // fragmentation total saturates here
  localparam logic [9:0] SLACK_MAX = 10'd1023;

  // request payload
  typedef struct packed {
    logic        mode;
    logic [11:0] req_size;
    logic [9:0]  block_offset;
  } bdy_in_t;

  // result payload
  typedef struct packed {
    logic [1:0]  status;
    logic [9:0]  alloc_offset;
    logic [9:0]  frag_total;
    logic [10:0] free_units;
  } bdy_out_t;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_A_RD,
    ST_A_CHK,
    ST_A_SPLIT,
    ST_F_RD,
    ST_F_CHK,
    ST_F_SCRD,
    ST_F_SCCHK,
    ST_F_MRD,
    ST_F_MCHK,
    ST_FIN
  } bdy_state_t;

endpackage

>>> src/bdy_ram.sv
// ----------------------------------------------------------------------------
// bdy_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module bdy_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

>>> src/bdy_ctrl.sv
// ----------------------------------------------------------------------------
// bdy_ctrl
// Sequencer for the buddy allocator: walks the free-bit tree held in the
// node RAM one read-modify-write at a time, keeps the free and slack totals.
// ----------------------------------------------------------------------------
module bdy_ctrl #(
  parameter int HEAP_LEVELS = bdy_pkg::HEAP_LEVELS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  bdy_pkg::bdy_in_t       in_req,
  output logic                   busy,
  output logic                   out_valid,
  output bdy_pkg::bdy_out_t      out_res,
  output logic                   mem_we,
  output logic [HEAP_LEVELS:0]   mem_addr,
  output logic                   mem_wdata,
  input  logic                   mem_rdata
);

  localparam int L   = HEAP_LEVELS;
  localparam int NW  = L + 1;
  localparam int LW  = $clog2(L + 1);
  localparam int AW  = (NW > 12) ? NW : 12;
  localparam int SZW = AW + 1;

  bdy_pkg::bdy_state_t state_r, state_nxt;

  logic [LW-1:0]     k_r, k_nxt;
  logic [LW-1:0]     lvl_r, lvl_nxt;
  logic [LW-1:0]     d_r, d_nxt;
  logic [NW-1:0]     node_r, node_nxt;
  logic [NW-1:0]     first_r, first_nxt;
  logic [NW-1:0]     up_r, up_nxt;
  logic [NW-1:0]     base_r, base_nxt;
  logic [NW-1:0]     scan_r, scan_nxt;
  logic [NW:0]       end_r, end_nxt;
  logic [NW-1:0]     absorbed_r, absorbed_nxt;
  logic [AW-1:0]     amt_r, amt_nxt;
  logic [9:0]        slack_r, slack_nxt;
  logic [NW-1:0]     free_r, free_nxt;
  logic [1:0]        status_r, status_nxt;
  logic [9:0]        offset_r, offset_nxt;
  logic [NW-1:0]     clr_r, clr_nxt;
  logic              out_valid_r, out_valid_nxt;
  bdy_pkg::bdy_out_t out_res_r, out_res_nxt;

  // request decode
  logic [SZW-1:0] size_w;
  logic           oversize;
  logic [LW-1:0]  k_calc;
  logic [SZW-1:0] amt_w;
  logic [NW-1:0]  first_k;
  logic [L-1:0]   boff_l;
  logic [NW-1:0]  fnode;

  // shared step conditions
  logic           rd_bit;
  logic           scan_last;
  logic           sc_last;
  logic           d_last;
  logic           split_more;
  logic [NW-1:0]  first_kr;
  logic [NW-1:0]  pow_k;
  logic [NW-1:0]  weight;
  logic [NW-1:0]  off_w;
  logic [SZW-1:0] sadd;
  logic [9:0]     slack_add_v;
  logic [9:0]     slack_sub_v;
  logic [NW-1:0]  free_rel;
  logic           sub_cond;

  // size to level, slack and tree node of the request
  always_comb begin
    size_w   = SZW'(in_req.req_size);
    oversize = size_w > (SZW'(1) << L);
    k_calc   = LW'(L);
    for (int i = L; i >= 0; i--) begin
      if ((SZW'(1) << i) >= size_w) begin
        k_calc = LW'(i);
      end
    end
    amt_w   = (SZW'(1) << k_calc) - size_w;
    first_k = NW'(1) << (L - int'(k_calc));
    boff_l  = L'(in_req.block_offset);
    fnode   = first_k | NW'(boff_l >> k_calc);
  end

  // conditions used by both the next-state and datapath logic
  always_comb begin
    rd_bit      = mem_rdata;
    scan_last   = ({1'b0, node_r} + (NW+1)'(1)) == {first_r, 1'b0};
    sc_last     = ({1'b0, scan_r} + (NW+1)'(1)) == end_r;
    d_last      = d_r == k_r;
    split_more  = lvl_r > k_r;
    first_kr    = NW'(1) << (L - int'(k_r));
    pow_k       = NW'(1) << k_r;
    weight      = NW'(1) << (k_r - d_r);
    off_w       = NW'((node_r ^ first_kr) << k_r);
    sadd        = SZW'(slack_r) + SZW'(amt_r);
    slack_add_v = (sadd > SZW'(bdy_pkg::SLACK_MAX)) ? bdy_pkg::SLACK_MAX : 10'(sadd);
    slack_sub_v = (SZW'(amt_r) > SZW'(slack_r)) ? 10'd0
                                                : 10'(SZW'(slack_r) - SZW'(amt_r));
    free_rel    = free_r + pow_k - absorbed_r;
    sub_cond    = (absorbed_r != pow_k) || (node_r == NW'(1));
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bdy_pkg::ST_CLEAR: begin
        if (clr_r == '1) state_nxt = bdy_pkg::ST_IDLE;
      end
      bdy_pkg::ST_IDLE: begin
        if (start) begin
          if (oversize) state_nxt = bdy_pkg::ST_FIN;
          else if (in_req.mode == bdy_pkg::MODE_ALLOC) state_nxt = bdy_pkg::ST_A_RD;
          else state_nxt = bdy_pkg::ST_F_RD;
        end
      end
      bdy_pkg::ST_A_RD: state_nxt = bdy_pkg::ST_A_CHK;
      bdy_pkg::ST_A_CHK: begin
        if (rd_bit) state_nxt = bdy_pkg::ST_A_SPLIT;
        else if (scan_last && first_r == NW'(1)) state_nxt = bdy_pkg::ST_FIN;
        else state_nxt = bdy_pkg::ST_A_RD;
      end
      bdy_pkg::ST_A_SPLIT: begin
        if (!split_more) state_nxt = bdy_pkg::ST_FIN;
      end
      bdy_pkg::ST_F_RD: state_nxt = bdy_pkg::ST_F_CHK;
      bdy_pkg::ST_F_CHK: begin
        if (rd_bit) state_nxt = bdy_pkg::ST_FIN;
        else if (up_r == NW'(1)) begin
          state_nxt = (k_r == '0) ? bdy_pkg::ST_F_MRD : bdy_pkg::ST_F_SCRD;
        end else state_nxt = bdy_pkg::ST_F_RD;
      end
      bdy_pkg::ST_F_SCRD: state_nxt = bdy_pkg::ST_F_SCCHK;
      bdy_pkg::ST_F_SCCHK: begin
        state_nxt = (sc_last && d_last) ? bdy_pkg::ST_F_MRD : bdy_pkg::ST_F_SCRD;
      end
      bdy_pkg::ST_F_MRD: begin
        state_nxt = (node_r == NW'(1)) ? bdy_pkg::ST_FIN : bdy_pkg::ST_F_MCHK;
      end
      bdy_pkg::ST_F_MCHK: begin
        state_nxt = rd_bit ? bdy_pkg::ST_F_MRD : bdy_pkg::ST_FIN;
      end
      bdy_pkg::ST_FIN: state_nxt = bdy_pkg::ST_IDLE;
      default: state_nxt = bdy_pkg::ST_IDLE;
    endcase
  end

  // datapath, memory port and result
  always_comb begin
    k_nxt         = k_r;
    lvl_nxt       = lvl_r;
    d_nxt         = d_r;
    node_nxt      = node_r;
    first_nxt     = first_r;
    up_nxt        = up_r;
    base_nxt      = base_r;
    scan_nxt      = scan_r;
    end_nxt       = end_r;
    absorbed_nxt  = absorbed_r;
    amt_nxt       = amt_r;
    slack_nxt     = slack_r;
    free_nxt      = free_r;
    status_nxt    = status_r;
    offset_nxt    = offset_r;
    clr_nxt       = clr_r;
    out_valid_nxt = 1'b0;
    out_res_nxt   = out_res_r;
    mem_we        = 1'b0;
    mem_addr      = node_r;
    mem_wdata     = 1'b0;
    case (state_r)
      // sweep the tree after reset, root left free
      bdy_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_r;
        mem_wdata = clr_r == NW'(1);
        clr_nxt   = clr_r + NW'(1);
      end
      // latch the request
      bdy_pkg::ST_IDLE: begin
        if (start) begin
          k_nxt        = k_calc;
          lvl_nxt      = k_calc;
          amt_nxt      = AW'(amt_w);
          offset_nxt   = '0;
          absorbed_nxt = '0;
          status_nxt   = oversize ? bdy_pkg::STATUS_TOOBIG : bdy_pkg::STATUS_OK;
          if (in_req.mode == bdy_pkg::MODE_ALLOC) begin
            node_nxt  = first_k;
            first_nxt = first_k;
          end else begin
            node_nxt = fnode;
            up_nxt   = fnode;
          end
        end
      end
      // scan levels upward for the lowest free block
      bdy_pkg::ST_A_RD: begin
        mem_addr = node_r;
      end
      bdy_pkg::ST_A_CHK: begin
        if (rd_bit) begin
          mem_we   = 1'b1;
          mem_addr = node_r;
        end else if (scan_last) begin
          if (first_r == NW'(1)) begin
            status_nxt = bdy_pkg::STATUS_NOSPACE;
          end else begin
            first_nxt = first_r >> 1;
            node_nxt  = first_r >> 1;
            lvl_nxt   = lvl_r + LW'(1);
          end
        end else begin
          node_nxt = node_r + NW'(1);
        end
      end
      // split down, freeing each upper half
      bdy_pkg::ST_A_SPLIT: begin
        if (split_more) begin
          mem_we    = 1'b1;
          mem_addr  = {node_r[NW-2:0], 1'b1};
          mem_wdata = 1'b1;
          node_nxt  = node_r << 1;
          lvl_nxt   = lvl_r - LW'(1);
        end else begin
          offset_nxt = 10'(off_w);
          free_nxt   = free_r - pow_k;
          slack_nxt  = slack_add_v;
        end
      end
      // check the block and its ancestors for a free one
      bdy_pkg::ST_F_RD: begin
        mem_addr = up_r;
      end
      bdy_pkg::ST_F_CHK: begin
        if (rd_bit) begin
          if (up_r == NW'(1) && up_r != node_r) slack_nxt = slack_sub_v;
        end else if (up_r == NW'(1)) begin
          d_nxt    = LW'(1);
          base_nxt = node_r << 1;
          scan_nxt = node_r << 1;
          end_nxt  = ({1'b0, node_r} << 1) + (NW+1)'(2);
        end else begin
          up_nxt = up_r >> 1;
        end
      end
      // absorb free blocks inside the freed block
      bdy_pkg::ST_F_SCRD: begin
        mem_addr = scan_r;
      end
      bdy_pkg::ST_F_SCCHK: begin
        if (rd_bit) begin
          mem_we       = 1'b1;
          mem_addr     = scan_r;
          absorbed_nxt = absorbed_r + weight;
        end
        if (sc_last) begin
          if (!d_last) begin
            d_nxt    = d_r + LW'(1);
            base_nxt = base_r << 1;
            scan_nxt = base_r << 1;
            end_nxt  = end_r << 1;
          end
        end else begin
          scan_nxt = scan_r + NW'(1);
        end
      end
      // merge with the buddy while it is free
      bdy_pkg::ST_F_MRD: begin
        if (node_r == NW'(1)) begin
          mem_we    = 1'b1;
          mem_addr  = node_r;
          mem_wdata = 1'b1;
          free_nxt  = free_rel;
          if (sub_cond) slack_nxt = slack_sub_v;
        end else begin
          mem_addr = node_r ^ NW'(1);
        end
      end
      bdy_pkg::ST_F_MCHK: begin
        mem_we = 1'b1;
        if (rd_bit) begin
          mem_addr = node_r ^ NW'(1);
          node_nxt = node_r >> 1;
        end else begin
          mem_addr  = node_r;
          mem_wdata = 1'b1;
          free_nxt  = free_rel;
          if (sub_cond) slack_nxt = slack_sub_v;
        end
      end
      // present the result for one cycle
      bdy_pkg::ST_FIN: begin
        out_valid_nxt            = 1'b1;
        out_res_nxt.status       = status_r;
        out_res_nxt.alloc_offset = offset_r;
        out_res_nxt.frag_total   = slack_r;
        out_res_nxt.free_units   = 11'(free_r);
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bdy_pkg::ST_CLEAR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      slack_r     <= '0;
      free_r      <= NW'(1) << L;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      slack_r     <= slack_nxt;
      free_r      <= free_nxt;
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    k_r        <= k_nxt;
    lvl_r      <= lvl_nxt;
    d_r        <= d_nxt;
    node_r     <= node_nxt;
    first_r    <= first_nxt;
    up_r       <= up_nxt;
    base_r     <= base_nxt;
    scan_r     <= scan_nxt;
    end_r      <= end_nxt;
    absorbed_r <= absorbed_nxt;
    amt_r      <= amt_nxt;
    status_r   <= status_nxt;
    offset_r   <= offset_nxt;
    out_res_r  <= out_res_nxt;
  end

  assign busy      = state_r != bdy_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule

>>> src/buddy_allocator.sv
// ----------------------------------------------------------------------------
// buddy_allocator
// Power-of-two buddy allocator over a heap of 2^HEAP_LEVELS units.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low; its result appears
// on out_res for exactly one cycle with out_valid high and must be captured
// then, since the block cannot be held off. The free bits of the block tree
// live in a single-port RAM of 2^(HEAP_LEVELS+1) one-bit entries and every
// step is one RAM access, so the time per request is set by that port: an
// allocate scans tree nodes (lowest offset first, level by level upward
// from the requested size), then splits down and finishes; a free checks
// the block and its ancestors, then each node inside the freed block, then
// merges with free buddies and finishes. An oversize request goes straight
// to the finish. After reset the RAM is swept once over all
// 2^(HEAP_LEVELS+1) entries, with busy held high throughout.
module buddy_allocator #(
  parameter int HEAP_LEVELS = bdy_pkg::HEAP_LEVELS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  bdy_pkg::bdy_in_t  in_req,
  output logic              out_valid,
  output bdy_pkg::bdy_out_t out_res
);

  logic                 mem_we;
  logic [HEAP_LEVELS:0] mem_addr;
  logic                 mem_wdata;
  logic                 mem_rdata;

  // node free-bit store
  bdy_ram #(
    .WIDTH (1),
    .DEPTH (1 << (HEAP_LEVELS + 1))
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // request sequencer
  bdy_ctrl #(
    .HEAP_LEVELS (HEAP_LEVELS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .in_req    (in_req),
    .busy      (busy),
    .out_valid (out_valid),
    .out_res   (out_res),
    .mem_we    (mem_we),
    .mem_addr  (mem_addr),
    .mem_wdata (mem_wdata),
    .mem_rdata (mem_rdata)
  );

  // a result only follows a cycle of work
  a_res_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without work in progress");

  // an accepted request always occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not start work");

  // free units never exceed the heap
  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (int'(out_res.free_units) <= (1 << HEAP_LEVELS)))
    else $error("free unit count beyond heap size");

endmodule

>>> dv/tb_buddy_allocator.sv
// ----------------------------------------------------------------------------
// tb_buddy_allocator
// Self-checking bench for the buddy allocator: a directed table of requests
// followed by random alloc/free traffic, every result checked against a
// behavioral heap model kept in the bench.
// ----------------------------------------------------------------------------
module tb_buddy_allocator;

  localparam int LEVELS = 10;
  localparam int UNITS  = 1 << LEVELS;
  localparam int NODES  = 2 * UNITS;
  localparam int CYCLE_LIMIT = 20000000;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  bdy_pkg::bdy_in_t  in_req = '0;
  logic              out_valid;
  bdy_pkg::bdy_out_t out_res;

  buddy_allocator #(.HEAP_LEVELS(LEVELS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_req(in_req), .out_valid(out_valid), .out_res(out_res)
  );

  always #2 clk = ~clk;

  // heap model state
  bit                heap_free[NODES];
  int unsigned       slack_acc;
  int unsigned       units_free;
  bdy_pkg::bdy_out_t pending_res[$];
  int                n_err = 0;
  // live allocations, for well-formed frees: {size, offset}
  int unsigned live_size[$];
  int unsigned live_off[$];

  function automatic int unsigned size_level(int unsigned sz);
    int unsigned k;
    k = 0;
    while (k < LEVELS && (1 << k) < sz) k++;
    return k;
  endfunction

  function automatic void heap_reset();
    foreach (heap_free[i]) heap_free[i] = 1'b0;
    heap_free[1] = 1'b1;
    slack_acc  = 0;
    units_free = UNITS;
  endfunction

  // allocate at level k, lowest offset at the smallest level that has a block
  function automatic bit heap_take(int unsigned k, output int unsigned off);
    int unsigned lvl, first, node;
    bit found;
    found = 0;
    node = 0;
    off = 0;
    for (lvl = k; lvl <= LEVELS && !found; lvl++) begin
      first = 1 << (LEVELS - lvl);
      for (int unsigned i = 0; i < first; i++)
        if (heap_free[first + i]) begin
          node = first + i;
          found = 1;
          break;
        end
    end
    if (!found) return 0;
    lvl--;
    heap_free[node] = 1'b0;
    while (lvl > k) begin
      node = node << 1;
      heap_free[node | 1] = 1'b1;
      lvl--;
    end
    off = (node - (1 << (LEVELS - k))) << k;
    units_free -= 1 << k;
    return 1;
  endfunction

  // free the level-k block at off, absorbing inner free blocks, then merge up
  function automatic void heap_give(int unsigned k, int unsigned off);
    int unsigned node, up, first, cnt;
    node = (1 << (LEVELS - k)) + (off >> k);
    for (up = node; up >= 1; up >>= 1)
      if (heap_free[up]) return;
    for (int unsigned j = 0; j < k; j++) begin
      first = node << (k - j);
      cnt = 1 << (k - j);
      for (int unsigned i = 0; i < cnt; i++)
        if (heap_free[first + i]) begin
          heap_free[first + i] = 1'b0;
          units_free -= 1 << j;
        end
    end
    units_free += 1 << k;
    heap_free[node] = 1'b1;
    while (node > 1 && heap_free[node ^ 1]) begin
      heap_free[node] = 1'b0;
      heap_free[node ^ 1] = 1'b0;
      node >>= 1;
      heap_free[node] = 1'b1;
    end
  endfunction

  function automatic bdy_pkg::bdy_out_t heap_step(bdy_pkg::bdy_in_t rq);
    bdy_pkg::bdy_out_t r;
    int unsigned       sz, k, rnd, eff, boff, aoff, free_before, node;
    bit                was_free;
    r = '0;
    sz = 32'(rq.req_size);
    boff = 32'(rq.block_offset) & (UNITS - 1);
    aoff = 0;
    if (sz > UNITS) begin
      r.status = bdy_pkg::STATUS_TOOBIG;
    end else begin
      k = size_level(sz);
      rnd = 1 << k;
      eff = sz;
      if (rq.mode == bdy_pkg::MODE_ALLOC) begin
        if (heap_take(k, aoff)) begin
          slack_acc = (slack_acc + rnd - eff > bdy_pkg::SLACK_MAX) ? bdy_pkg::SLACK_MAX
                                                                   : slack_acc + rnd - eff;
        end else begin
          r.status = bdy_pkg::STATUS_NOSPACE;
        end
      end else begin
        free_before = units_free;
        node = (1 << (LEVELS - k)) + (boff >> k);
        was_free = heap_free[node];
        heap_give(k, boff & ~(rnd - 1));
        if (units_free != free_before || (!was_free && heap_free[1]))
          slack_acc = (rnd - eff > slack_acc) ? 0 : slack_acc - (rnd - eff);
      end
    end
    r.alloc_offset = 10'(aoff);
    r.frag_total   = 10'(slack_acc);
    r.free_units   = 11'(units_free);
    return r;
  endfunction

  // directed table; want checked only where has_want is set
  typedef struct {
    bdy_pkg::bdy_in_t  rq;
    bit                has_want;
    bdy_pkg::bdy_out_t want;
  } dir_row_t;
  dir_row_t dir_rows[$];

  function automatic bdy_pkg::bdy_in_t mk(logic m, int unsigned sz, int unsigned off);
    bdy_pkg::bdy_in_t r;
    r.mode = m;
    r.req_size = 12'(sz);
    r.block_offset = 10'(off);
    return r;
  endfunction

  function automatic bdy_pkg::bdy_out_t res(logic [1:0] st, int unsigned ao,
                                            int unsigned fr, int unsigned fu);
    bdy_pkg::bdy_out_t r;
    r.status = st;
    r.alloc_offset = 10'(ao);
    r.frag_total = 10'(fr);
    r.free_units = 11'(fu);
    return r;
  endfunction

  task automatic add_row(bdy_pkg::bdy_in_t rq, bit hw = 0, bdy_pkg::bdy_out_t w = '0);
    dir_row_t d;
    d.rq = rq;
    d.has_want = hw;
    d.want = w;
    dir_rows.push_back(d);
  endtask

  // random gap, mostly short
  task automatic idle_gap();
    int unsigned g;
    g = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 60) :
        ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 3));
    repeat (g) @(posedge clk);
  endtask

  // issue one request and queue its expected result
  task automatic send_req(bdy_pkg::bdy_in_t rq, bit hw, bdy_pkg::bdy_out_t w, bit gaps);
    bdy_pkg::bdy_out_t p;
    if (gaps) idle_gap();
    start  <= 1'b1;
    in_req <= rq;
    @(posedge clk);
    while (busy) @(posedge clk);
    start  <= 1'b0;
    in_req <= bdy_pkg::bdy_in_t'($urandom());
    p = heap_step(rq);
    if (hw && p !== w) begin
      $error("table row disagrees with heap model: exp %h got %h", w, p);
      n_err++;
    end
    pending_res.push_back(hw ? w : p);
    if (rq.mode == bdy_pkg::MODE_ALLOC && p.status == bdy_pkg::STATUS_OK
        && rq.req_size != 0) begin
      live_size.push_back(32'(rq.req_size));
      live_off.push_back(32'(p.alloc_offset));
    end
    // start goes low before the next request is raised
    @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    bdy_pkg::bdy_out_t e;
    if (rst_n && out_valid) begin
      if (pending_res.size() == 0) begin
        $error("result with no request outstanding: %h", out_res);
        n_err++;
      end else begin
        e = pending_res.pop_front();
        if (out_res.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_res.status); n_err++;
        end
        if (out_res.alloc_offset !== e.alloc_offset) begin
          $error("alloc_offset exp %0d got %0d", e.alloc_offset, out_res.alloc_offset);
          n_err++;
        end
        if (out_res.frag_total !== e.frag_total) begin
          $error("frag_total exp %0d got %0d", e.frag_total, out_res.frag_total);
          n_err++;
        end
        if (out_res.free_units !== e.free_units) begin
          $error("free_units exp %0d got %0d", e.free_units, out_res.free_units);
          n_err++;
        end
      end
    end
  end

  // timeout watchdog
  initial begin
    int unsigned cyc;
    cyc = 0;
    forever begin
      @(posedge clk);
      cyc++;
      if (cyc > CYCLE_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned      idx, k, sz, off, pick, lo_mask;
    bdy_pkg::bdy_in_t rq;
    heap_reset();
    // directed: reset state, extremes, every special case
    add_row(mk(bdy_pkg::MODE_ALLOC, 2048, 0), 1, res(bdy_pkg::STATUS_TOOBIG, 0, 0, 1024));
    add_row(mk(bdy_pkg::MODE_FREE, 4095, 1023), 1, res(bdy_pkg::STATUS_TOOBIG, 0, 0, 1024));
    // double free
    add_row(mk(bdy_pkg::MODE_FREE, 1, 5), 1, res(bdy_pkg::STATUS_OK, 0, 0, 1024));
    add_row(mk(bdy_pkg::MODE_ALLOC, 1024, 0), 1, res(bdy_pkg::STATUS_OK, 0, 0, 0));
    // no space
    add_row(mk(bdy_pkg::MODE_ALLOC, 1, 0), 1, res(bdy_pkg::STATUS_NOSPACE, 0, 0, 0));
    add_row(mk(bdy_pkg::MODE_FREE, 1024, 0), 1, res(bdy_pkg::STATUS_OK, 0, 0, 1024));
    add_row(mk(bdy_pkg::MODE_ALLOC, 0, 0));       // zero size
    add_row(mk(bdy_pkg::MODE_ALLOC, 3, 1023));
    add_row(mk(bdy_pkg::MODE_ALLOC, 513, 0));
    add_row(mk(bdy_pkg::MODE_ALLOC, 100, 0));
    add_row(mk(bdy_pkg::MODE_FREE, 3, 7));        // unaligned free
    add_row(mk(bdy_pkg::MODE_FREE, 0, 0));
    add_row(mk(bdy_pkg::MODE_ALLOC, 1025, 0));
    add_row(mk(bdy_pkg::MODE_ALLOC, 1, 0));
    add_row(mk(bdy_pkg::MODE_FREE, 1024, 1023));  // free of a split block
    add_row(mk(bdy_pkg::MODE_ALLOC, 1000, 0));
    add_row(mk(bdy_pkg::MODE_ALLOC, 1000, 0));
    add_row(mk(bdy_pkg::MODE_FREE, 1000, 0));
    add_row(mk(bdy_pkg::MODE_FREE, 1000, 0));
    add_row(mk(bdy_pkg::MODE_ALLOC, 2047, 682));
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    // walk the directed table
    foreach (dir_rows[i]) send_req(dir_rows[i].rq, dir_rows[i].has_want, dir_rows[i].want, 0);
    live_size.delete();
    live_off.delete();
    for (idx = 0; idx < 1000; idx++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) begin
        // allocation, mostly small
        k = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 10) : $urandom_range(0, 5);
        sz = (k == 0) ? $urandom_range(0, 1) : $urandom_range((1 << (k - 1)) + 1, 1 << k);
        rq = mk(bdy_pkg::MODE_ALLOC, sz, $urandom());
      end else if (pick < 85 && live_size.size() > 0) begin
        // free a live block
        off = $urandom_range(0, live_size.size() - 1);
        lo_mask = (1 << size_level(live_size[off])) - 1;
        rq = mk(bdy_pkg::MODE_FREE, live_size[off], live_off[off] | ($urandom() & lo_mask));
        live_size.delete(off);
        live_off.delete(off);
      end else if (pick < 95) begin
        rq = mk(1'($urandom()), $urandom_range(0, 1024), $urandom());
      end else begin
        rq = mk(1'($urandom()), $urandom_range(1025, 4095), $urandom());
      end
      send_req(rq, 0, '0, 1);
    end
    while (pending_res.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (n_err == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
